[hdl/vna_pkg.sv]
// Types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;

    localparam int IDX_W  = 10;
    localparam int FLD_W  = 16;
    localparam int MUL_W  = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 48;
    localparam int MAG_W  = 15;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int LEN_W  = 32;
    localparam int Q_W    = 31;
    localparam int RES_W  = 16;
    localparam int SREM_W = 18;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(RES_W - 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CORNER = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [13:0] {
        S_CLR      = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_POS_RD   = 14'b00000000000100,
        S_POS_WAIT = 14'b00000000001000,
        S_CROSS    = 14'b00000000010000,
        S_ACC_RD   = 14'b00000000100000,
        S_ACC_WR   = 14'b00000001000000,
        S_NRM_WAIT = 14'b00000010000000,
        S_NORM     = 14'b00000100000000,
        S_SQ       = 14'b00001000000000,
        S_DINIT    = 14'b00010000000000,
        S_DIV      = 14'b00100000000000,
        S_SQRT     = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

endpackage

[hdl/vertex_normal_accumulator.sv]
// Vertex normal accumulator: position and accumulator memories, one shared
// multiplier, a restoring divider and a digit square root under one sequencer.
// Depends on vna_pkg.
//
// The closing corner of a triangle runs the triangle update; a read shift-normalises
// and then divides and takes a square root per component; clear sweeps every entry
// of the accumulator memory. After reset the same sweep runs before the first
// transfer is taken; configuration writes are taken at any time.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_triangle_source,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [vna_pkg::IDX_W-1:0]       vertex_index,
    input  logic signed [vna_pkg::FLD_W-1:0] pos_x,
    input  logic signed [vna_pkg::FLD_W-1:0] pos_y,
    input  logic signed [vna_pkg::FLD_W-1:0] pos_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [vna_pkg::FLD_W-1:0] normal_x,
    output logic signed [vna_pkg::FLD_W-1:0] normal_y,
    output logic signed [vna_pkg::FLD_W-1:0] normal_z,
    output logic                            zero_length
);
    import vna_pkg::*;

    localparam int CW    = (COORD_BITS < FLD_W) ? COORD_BITS : FLD_W;
    localparam int DEPTH = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int POS_W = 3 * CW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
            begin
                return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end
            return s[ACC_W-1:0];
        end
    endfunction

    state_t state_reg, state_next;

    logic              src_reg;
    logic [1:0]        count_reg;
    logic [AW-1:0]     first_reg, second_reg, third_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [1:0]        k_reg;
    logic [2:0]        step_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;

    logic [POS_W-1:0]   pos_mem [DEPTH];
    logic [3*ACC_W-1:0] acc_mem [DEPTH];
    logic [POS_W-1:0]   pos_rd_reg;
    logic [3*ACC_W-1:0] acc_rd_reg;

    logic signed [MUL_W-1:0]  p0_reg [3];
    logic signed [MUL_W-1:0]  a_reg [3];
    logic signed [MUL_W-1:0]  b_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  cr_reg;
    logic [ACC_W-1:0]         cross_reg [3];
    logic                     neg_reg [3];
    logic [ACC_W-1:0]         mag_reg [3];
    logic [ACC_W-1:0]         m_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    logic [LEN_W-1:0]         len2_reg;
    logic [LEN_W-1:0]         drem_reg;
    logic [Q_W-1:0]           dq_reg;
    logic [LEN_W-1:0]         sqt_reg;
    logic [RES_W-1:0]         sres_reg;
    logic [SREM_W-1:0]        srem_reg;
    logic [FLD_W-1:0]         nout_reg [3];
    logic                     zl_reg;
    logic [FLD_W-1:0]         nx_reg, ny_reg, nz_reg;
    logic                     zlo_reg;

    op_t                      op;
    logic                     accept;
    logic                     in_range;
    logic                     take;
    logic [AW-1:0]            in_addr;
    logic [AW-1:0]            corner_sel;
    logic [AW-1:0]            acc_rd_addr;
    logic                     acc_wr_en;
    logic [AW-1:0]            acc_wr_addr;
    logic [3*ACC_W-1:0]       acc_wr_data;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [MUL_W-1:0]  pos_c [3];
    logic                     nv_neg [3];
    logic [ACC_W-1:0]         nv_mag [3];
    logic [ACC_W-1:0]         nv_max;
    logic                     norm_done;
    logic [SQ_W-1:0]          sq_sel;
    logic                     dbit;
    logic [LEN_W:0]           dtrial;
    logic                     dge;
    logic [Q_W-1:0]           dq_next;
    logic [SREM_W+1:0]        srem2;
    logic [SREM_W+1:0]        strial;
    logic                     sge;
    logic [RES_W-1:0]         sres_next;
    logic [RES_W:0]           lo;
    logic                     out_free;
    logic [2:0]               cidx;
    logic [1:0]               sidx;

    assign op        = op_t'(opcode);
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = (32'(vertex_index) < 32'(MAX_VERTICES));
    assign in_addr   = vertex_index[AW-1:0];
    assign take      = in_range && (((op == OP_LOAD) && src_reg)
                                 || ((op == OP_CORNER) && !src_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign normal_z  = nz_reg;
    assign zero_length = zlo_reg;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_sel = first_reg;
            2'd1:    corner_sel = second_reg;
            default: corner_sel = third_reg;
        endcase
        case (k_reg)
            2'd0:    sq_sel = sq_reg[0];
            2'd1:    sq_sel = sq_reg[1];
            default: sq_sel = sq_reg[2];
        endcase
    end

    assign acc_rd_addr = (state_reg == S_IDLE) ? in_addr : corner_sel;

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_LOAD) && in_range)
        begin
            pos_mem[in_addr] <= {pos_z[CW-1:0], pos_y[CW-1:0], pos_x[CW-1:0]};
        end
        pos_rd_reg <= pos_mem[corner_sel];
    end

    always_ff @(posedge clk)
    begin
        if (acc_wr_en)
        begin
            acc_mem[acc_wr_addr] <= acc_wr_data;
        end
        acc_rd_reg <= acc_mem[acc_rd_addr];
    end

    always_comb
    begin
        acc_wr_en   = 1'b0;
        acc_wr_addr = corner_sel;
        acc_wr_data = '0;
        if (state_reg == S_CLR)
        begin
            acc_wr_en   = 1'b1;
            acc_wr_addr = clr_cnt_reg;
        end
        else if (state_reg == S_ACC_WR)
        begin
            acc_wr_en   = 1'b1;
            acc_wr_data = {sat_add(acc_rd_reg[2*ACC_W +: ACC_W], cross_reg[2]),
                           sat_add(acc_rd_reg[ACC_W +: ACC_W], cross_reg[1]),
                           sat_add(acc_rd_reg[0 +: ACC_W], cross_reg[0])};
        end
    end

    // combinational datapath terms
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pos_c[c]  = MUL_W'(signed'(pos_rd_reg[c*CW +: CW]));
            nv_neg[c] = acc_rd_reg[c*ACC_W + ACC_W - 1];
            nv_mag[c] = nv_neg[c] ? (ACC_W'(0) - acc_rd_reg[c*ACC_W +: ACC_W])
                                  : acc_rd_reg[c*ACC_W +: ACC_W];
        end
        nv_max = nv_mag[0];
        if (nv_mag[1] > nv_max) nv_max = nv_mag[1];
        if (nv_mag[2] > nv_max) nv_max = nv_mag[2];

        norm_done = !(|m_reg[ACC_W-1:MAG_W]) && m_reg[MAG_W-1];

        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                3'd0:    begin mul_a = a_reg[1]; mul_b = b_reg[2]; end
                3'd1:    begin mul_a = a_reg[2]; mul_b = b_reg[1]; end
                3'd2:    begin mul_a = a_reg[2]; mul_b = b_reg[0]; end
                3'd3:    begin mul_a = a_reg[0]; mul_b = b_reg[2]; end
                3'd4:    begin mul_a = a_reg[0]; mul_b = b_reg[1]; end
                3'd5:    begin mul_a = a_reg[1]; mul_b = b_reg[0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            case (step_reg)
                3'd0:    mul_a = MUL_W'(mag_reg[0][MAG_W-1:0]);
                3'd1:    mul_a = MUL_W'(mag_reg[1][MAG_W-1:0]);
                3'd2:    mul_a = MUL_W'(mag_reg[2][MAG_W-1:0]);
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end

        cidx = step_reg - 3'd1;
        sidx = 2'(step_reg - 3'd1);

        dbit    = (cnt_reg == '0) ? sq_sel[0] : 1'b0;
        dtrial  = {drem_reg, dbit} - {1'b0, len2_reg};
        dge     = !dtrial[LEN_W];
        dq_next = {dq_reg[Q_W-2:0], dge};

        srem2     = {srem_reg, sqt_reg[LEN_W-1:LEN_W-2]};
        strial    = {2'b00, sres_reg, 2'b01};
        sge       = (srem2 >= strial);
        sres_next = {sres_reg[RES_W-2:0], sge};
        lo        = ({1'b0, sres_next} + (RES_W+1)'(1)) >> 1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:      if (clr_cnt_reg == LAST_ADDR) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:            state_next = S_CLR;
                        OP_LOAD, OP_CORNER:  if (take && (count_reg == 2'd2)) state_next = S_POS_RD;
                        OP_READ:             state_next = in_range ? S_NRM_WAIT : S_OUT;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_POS_RD:   state_next = S_POS_WAIT;
            S_POS_WAIT: state_next = (k_reg == 2'd2) ? S_CROSS : S_POS_RD;
            S_CROSS:    if (step_reg == 3'd6) state_next = S_ACC_RD;
            S_ACC_RD:   state_next = S_ACC_WR;
            S_ACC_WR:   state_next = (k_reg == 2'd2) ? S_IDLE : S_ACC_RD;
            S_NRM_WAIT: state_next = (nv_max == '0) ? S_OUT : S_NORM;
            S_NORM:     if (norm_done) state_next = S_SQ;
            S_SQ:       if (step_reg == 3'd3) state_next = S_DINIT;
            S_DINIT:    state_next = S_DIV;
            S_DIV:      if (cnt_reg == DIV_LAST) state_next = S_SQRT;
            S_SQRT:
            begin
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = (k_reg == 2'd2) ? S_OUT : S_DINIT;
                end
            end
            S_OUT:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            src_reg       <= 1'b0;
            count_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            third_reg     <= '0;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                src_reg <= cfg_triangle_source;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:      clr_cnt_reg <= clr_cnt_reg + AW'(1);
                S_IDLE:
                begin
                    k_reg    <= '0;
                    step_reg <= '0;
                    if (accept && (op == OP_CLEAR))
                    begin
                        clr_cnt_reg <= '0;
                        count_reg   <= '0;
                    end
                    else if (accept && take)
                    begin
                        case (count_reg)
                            2'd0:
                            begin
                                first_reg <= in_addr;
                                count_reg <= 2'd1;
                            end
                            2'd1:
                            begin
                                second_reg <= in_addr;
                                count_reg  <= 2'd2;
                            end
                            default:
                            begin
                                third_reg <= in_addr;
                                count_reg <= '0;
                            end
                        endcase
                    end
                end
                S_POS_WAIT: k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                S_CROSS:    step_reg <= step_reg + 3'd1;
                S_ACC_WR:   k_reg <= k_reg + 2'd1;
                S_NORM:
                begin
                    k_reg    <= '0;
                    step_reg <= '0;
                end
                S_SQ:       step_reg <= step_reg + 3'd1;
                S_DINIT:    cnt_reg <= '0;
                S_DIV:      cnt_reg <= (cnt_reg == DIV_LAST) ? '0 : cnt_reg + CNT_W'(1);
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SQRT_LAST)
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_OUT && out_free)
        begin
            nx_reg  <= nout_reg[0];
            ny_reg  <= nout_reg[1];
            nz_reg  <= nout_reg[2];
            zlo_reg <= zl_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                for (int c = 0; c < 3; c++) nout_reg[c] <= '0;
                zl_reg <= 1'b1;
            end
            S_POS_WAIT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (k_reg == 2'd0)      p0_reg[c] <= pos_c[c];
                    else if (k_reg == 2'd1) a_reg[c]  <= pos_c[c] - p0_reg[c];
                    else                    b_reg[c]  <= pos_c[c] - p0_reg[c];
                end
            end
            S_CROSS:
            begin
                if (step_reg != 3'd0)
                begin
                    if (!cidx[0])
                    begin
                        cr_reg <= ACC_W'(prod_reg);
                    end
                    else
                    begin
                        cross_reg[cidx[2:1]] <= cr_reg - ACC_W'(prod_reg);
                    end
                end
            end
            S_NRM_WAIT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    neg_reg[c] <= nv_neg[c];
                    mag_reg[c] <= nv_mag[c];
                end
                m_reg <= nv_max;
            end
            S_NORM:
            begin
                len2_reg <= '0;
                zl_reg   <= 1'b0;
                if (|m_reg[ACC_W-1:MAG_W])
                begin
                    for (int c = 0; c < 3; c++) mag_reg[c] <= mag_reg[c] >> 1;
                    m_reg <= m_reg >> 1;
                end
                else if (!m_reg[MAG_W-1])
                begin
                    for (int c = 0; c < 3; c++) mag_reg[c] <= mag_reg[c] << 1;
                    m_reg <= m_reg << 1;
                end
            end
            S_SQ:
            begin
                if (step_reg != 3'd0)
                begin
                    sq_reg[sidx] <= prod_reg[SQ_W-1:0];
                    len2_reg     <= len2_reg + LEN_W'(prod_reg[SQ_W-1:0]);
                end
            end
            S_DINIT:
            begin
                drem_reg <= LEN_W'(sq_sel >> 1);
                dq_reg   <= '0;
            end
            S_DIV:
            begin
                drem_reg <= dge ? dtrial[LEN_W-1:0] : {drem_reg[LEN_W-2:0], dbit};
                dq_reg   <= dq_next;
                if (cnt_reg == DIV_LAST)
                begin
                    sqt_reg  <= LEN_W'(dq_next);
                    sres_reg <= '0;
                    srem_reg <= '0;
                end
            end
            S_SQRT:
            begin
                srem_reg <= sge ? SREM_W'(srem2 - strial) : srem2[SREM_W-1:0];
                sres_reg <= sres_next;
                sqt_reg  <= sqt_reg << 2;
                if (cnt_reg == SQRT_LAST)
                begin
                    nout_reg[k_reg] <= neg_reg[k_reg] ? (FLD_W'(0) - FLD_W'(lo))
                                                      : FLD_W'(lo);
                end
            end
            default: ;
        endcase
    end

endmodule
